FILE: sv/small_set_operation_engine_top_defines.svh
// Assertion macros for the set engine
`ifndef SMALL_SET_OPERATION_ENGINE_TOP_DEFINES_SVH
`define SMALL_SET_OPERATION_ENGINE_TOP_DEFINES_SVH

`define SOSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define SOSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/sose_pkg.sv
package sose_pkg;

  localparam int CAPACITY_DEF    = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ACT_ADD_A = 3'd0,
    ACT_ADD_B = 3'd1,
    ACT_RUN   = 3'd2,
    ACT_QUERY = 3'd3,
    ACT_CLEAR = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    OP_UNION  = 2'd0,
    OP_INTER  = 2'd1,
    OP_DIFF   = 2'd2,
    OP_SUBSET = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ELEM  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_OVER  = 2'd2,
    KIND_REL   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REL_NO     = 2'd0,
    REL_YES    = 2'd1,
    REL_PROPER = 2'd2
  } rel_t;

  typedef struct packed {
    logic shift_a;
    logic shift_b;
    logic wr_a;
    logic wr_b;
  } cell_ctrl_t;

endpackage

FILE: sv/small_set_operation_engine_top.sv
// Set engine on two rings of cells. Cell i holds A[i] and B[i] whenever the block is idle;
// a scan rotates a ring past the head cell one step per cycle and compares the head with a
// probe. An add to a full set sends a marker word, which waits for the output. A run visits
// each element of the outer set and rotates the inner ring a full turn for it; union,
// intersection and difference take a counting pass and an emit pass (union also rotates A
// once between them), subset test takes two passes, plus stalls on the output.
module small_set_operation_engine_top #(
  parameter int CAPACITY    = sose_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = sose_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,      // op_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value
  input  logic [2:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // result_value[31:0], relation[33:32], result_count[39:34]
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast
);
  import sose_pkg::*;

  localparam int IDXW = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_OUTER  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_EMITA  = 6'b010000,
    S_ONE    = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    PH_QUERY,
    PH_COUNT,
    PH_EMIT,
    PH_SUB1,
    PH_SUB2
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic [1:0] op_mode;
  logic [CNTW-1:0] count_a, count_a_next, count_b, count_b_next;
  logic [CNTW-1:0] o, o_next, t, t_next, n_cnt, n_cnt_next, emitted, emitted_next;
  logic outer_b, outer_b_next, inner_b, inner_b_next, keep_found, keep_found_next;
  logic found, found_next, sub, sub_next, extra, extra_next, is_union, is_union_next;
  logic [VALUE_WIDTH-1:0] qval, qval_next, vin;
  kind_t pend_kind, pend_kind_next;
  rel_t pend_rel, pend_rel_next;

  cell_ctrl_t ctrl;
  logic [IDXW-1:0] wr_idx;
  logic [VALUE_WIDTH-1:0] a_chain [CAPACITY];
  logic [VALUE_WIDTH-1:0] b_chain [CAPACITY];
  logic [VALUE_WIDTH-1:0] a_head, b_head, probe, inner_head, outer_head;
  logic [CNTW-1:0] inner_cnt, outer_cnt;
  logic slot, keep, hit;

  logic out_load;
  logic [31:0] ld_value;
  kind_t ld_kind;
  rel_t ld_rel;
  logic [5:0] ld_cnt;
  logic ld_last;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sose_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .IDXW(IDXW),
      .INDEX(i)
    ) u_cell (
      .clk(clk),
      .ctrl(ctrl),
      .wr_idx(wr_idx),
      .wdata(vin),
      .a_in(a_chain[(i + 1) % CAPACITY]),
      .b_in(b_chain[(i + 1) % CAPACITY]),
      .a_val(a_chain[i]),
      .b_val(b_chain[i])
    );
  end

  assign vin        = VALUE_WIDTH'($signed(s_axis_tdata));
  assign a_head     = a_chain[0];
  assign b_head     = b_chain[0];
  assign inner_head = inner_b ? b_head : a_head;
  assign outer_head = outer_b ? b_head : a_head;
  assign inner_cnt  = inner_b ? count_b : count_a;
  assign outer_cnt  = outer_b ? count_b : count_a;
  assign probe      = (phase == PH_QUERY) ? qval : outer_head;
  assign hit        = (t < inner_cnt) && (inner_head == probe);
  assign keep       = (found == keep_found);
  assign slot       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    count_a_next    = count_a;
    count_b_next    = count_b;
    o_next          = o;
    t_next          = t;
    n_cnt_next      = n_cnt;
    emitted_next    = emitted;
    outer_b_next    = outer_b;
    inner_b_next    = inner_b;
    keep_found_next = keep_found;
    found_next      = found;
    sub_next        = sub;
    extra_next      = extra;
    is_union_next   = is_union;
    qval_next       = qval;
    pend_kind_next  = pend_kind;
    pend_rel_next   = pend_rel;
    ctrl            = '0;
    wr_idx          = '0;
    out_load        = 1'b0;
    ld_value        = '0;
    ld_kind         = KIND_ELEM;
    ld_rel          = REL_NO;
    ld_cnt          = '0;
    ld_last         = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            ACT_ADD_A: begin
              if (count_a == CNTW'(CAPACITY)) begin
                pend_kind_next = KIND_OVER;
                pend_rel_next  = REL_NO;
                state_next     = S_ONE;
              end else begin
                ctrl.wr_a    = 1'b1;
                wr_idx       = count_a[IDXW-1:0];
                count_a_next = count_a + 1'b1;
              end
            end
            ACT_ADD_B: begin
              if (count_b == CNTW'(CAPACITY)) begin
                pend_kind_next = KIND_OVER;
                pend_rel_next  = REL_NO;
                state_next     = S_ONE;
              end else begin
                ctrl.wr_b    = 1'b1;
                wr_idx       = count_b[IDXW-1:0];
                count_b_next = count_b + 1'b1;
              end
            end
            ACT_RUN: begin
              o_next        = '0;
              is_union_next = 1'b0;
              n_cnt_next    = '0;
              state_next    = S_OUTER;
              phase_next    = PH_COUNT;
              unique case (op_t'(op_mode))
                OP_UNION: begin
                  if (({1'b0, count_a} + {1'b0, count_b}) > (CNTW + 1)'(CAPACITY)) begin
                    pend_kind_next = KIND_OVER;
                    pend_rel_next  = REL_NO;
                    state_next     = S_ONE;
                  end
                  outer_b_next    = 1'b1;
                  inner_b_next    = 1'b0;
                  keep_found_next = 1'b0;
                  n_cnt_next      = count_a;
                  is_union_next   = 1'b1;
                end
                OP_INTER: begin
                  outer_b_next    = 1'b1;
                  inner_b_next    = 1'b0;
                  keep_found_next = 1'b1;
                end
                OP_DIFF: begin
                  outer_b_next    = 1'b0;
                  inner_b_next    = 1'b1;
                  keep_found_next = 1'b0;
                end
                OP_SUBSET: begin
                  outer_b_next = 1'b1;
                  inner_b_next = 1'b0;
                  sub_next     = 1'b1;
                  extra_next   = 1'b0;
                  phase_next   = PH_SUB1;
                end
                default: ;
              endcase
            end
            ACT_QUERY: begin
              qval_next    = vin;
              phase_next   = PH_QUERY;
              inner_b_next = 1'b0;
              t_next       = '0;
              found_next   = 1'b0;
              state_next   = S_SCAN;
            end
            ACT_CLEAR: begin
              count_a_next = '0;
              count_b_next = '0;
            end
            default: ;
          endcase
        end
      end

      S_OUTER: begin
        if (o == CNTW'(CAPACITY)) begin
          o_next = '0;
          case (phase)
            PH_COUNT: begin
              emitted_next = '0;
              if (n_cnt == '0) begin
                pend_kind_next = KIND_EMPTY;
                pend_rel_next  = REL_NO;
                state_next     = S_ONE;
              end else if (is_union) begin
                t_next     = '0;
                state_next = S_EMITA;
              end else begin
                phase_next = PH_EMIT;
              end
            end
            PH_SUB1: begin
              phase_next   = PH_SUB2;
              outer_b_next = 1'b0;
              inner_b_next = 1'b1;
            end
            PH_SUB2: begin
              pend_kind_next = KIND_REL;
              pend_rel_next  = !sub ? REL_NO : (extra ? REL_PROPER : REL_YES);
              state_next     = S_ONE;
            end
            default: state_next = S_IDLE;
          endcase
        end else if (o < outer_cnt) begin
          t_next     = '0;
          found_next = 1'b0;
          state_next = S_SCAN;
        end else begin
          ctrl.shift_a = !outer_b;
          ctrl.shift_b = outer_b;
          o_next       = o + 1'b1;
        end
      end

      S_SCAN: begin
        if (hit) begin
          found_next = 1'b1;
        end
        ctrl.shift_a = !inner_b;
        ctrl.shift_b = inner_b;
        t_next       = t + 1'b1;
        if (t == CNTW'(CAPACITY - 1)) begin
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (phase == PH_QUERY) begin
          pend_kind_next = KIND_REL;
          pend_rel_next  = found ? REL_YES : REL_NO;
          state_next     = S_ONE;
        end else if (phase == PH_EMIT && keep && !slot) begin
          state_next = S_DECIDE;
        end else begin
          if (phase == PH_COUNT && keep) begin
            n_cnt_next = n_cnt + 1'b1;
          end
          if (phase == PH_EMIT && keep) begin
            out_load     = 1'b1;
            ld_value     = 32'(outer_head);
            ld_cnt       = 6'(n_cnt);
            ld_last      = (CNTW'(emitted + 1'b1) == n_cnt);
            emitted_next = emitted + 1'b1;
          end
          if (phase == PH_SUB1 && !found) begin
            sub_next = 1'b0;
          end
          if (phase == PH_SUB2 && !found) begin
            extra_next = 1'b1;
          end
          ctrl.shift_a = !outer_b;
          ctrl.shift_b = outer_b;
          o_next       = o + 1'b1;
          state_next   = S_OUTER;
        end
      end

      S_EMITA: begin
        if (!(t < count_a) || slot) begin
          if (t < count_a) begin
            out_load     = 1'b1;
            ld_value     = 32'(a_head);
            ld_cnt       = 6'(n_cnt);
            ld_last      = (CNTW'(emitted + 1'b1) == n_cnt);
            emitted_next = emitted + 1'b1;
          end
          ctrl.shift_a = 1'b1;
          t_next       = t + 1'b1;
          if (t == CNTW'(CAPACITY - 1)) begin
            phase_next   = PH_EMIT;
            outer_b_next = 1'b1;
            inner_b_next = 1'b0;
            o_next       = '0;
            state_next   = S_OUTER;
          end
        end
      end

      S_ONE: begin
        if (slot) begin
          out_load   = 1'b1;
          ld_kind    = pend_kind;
          ld_rel     = pend_rel;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_QUERY;
      op_mode       <= OP_UNION;
      count_a       <= '0;
      count_b       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      count_a <= count_a_next;
      count_b <= count_b_next;
      if (cfg_we) begin
        op_mode <= cfg_wdata;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    o          <= o_next;
    t          <= t_next;
    n_cnt      <= n_cnt_next;
    emitted    <= emitted_next;
    outer_b    <= outer_b_next;
    inner_b    <= inner_b_next;
    keep_found <= keep_found_next;
    found      <= found_next;
    sub        <= sub_next;
    extra      <= extra_next;
    is_union   <= is_union_next;
    qval       <= qval_next;
    pend_kind  <= pend_kind_next;
    pend_rel   <= pend_rel_next;
    if (out_load) begin
      m_axis_tdata <= {ld_cnt, ld_rel, ld_value};
      m_axis_tuser <= ld_kind;
      m_axis_tlast <= ld_last;
    end
  end

`include "small_set_operation_engine_top_defines.svh"

  `SOSE_ASSERT_NOW(a_count_bound, 1'b1, (count_a <= CNTW'(CAPACITY)) && (count_b <= CNTW'(CAPACITY)), "set count above capacity")
  `SOSE_ASSERT_NOW(a_non_elem_clean, m_axis_tvalid && (m_axis_tuser != KIND_ELEM), (m_axis_tdata[31:0] == '0) && (m_axis_tdata[39:34] == '0) && m_axis_tlast, "marker word carries data")
  `SOSE_ASSERT_NOW(a_emit_bound, ((state == S_DECIDE) && (phase == PH_EMIT)) || (state == S_EMITA), emitted <= n_cnt, "more words emitted than counted")
  `SOSE_ASSERT_NEXT(a_busy_no_take, state != S_IDLE, !$past(s_axis_tready) || $past(state) == S_IDLE, "input taken while busy")

endmodule

FILE: sv/sose_cell.sv
module sose_cell #(
  parameter int VALUE_WIDTH = sose_pkg::VALUE_WIDTH_DEF,
  parameter int IDXW        = 5,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  sose_pkg::cell_ctrl_t   ctrl,
  input  logic [IDXW-1:0]        wr_idx,
  input  logic [VALUE_WIDTH-1:0] wdata,
  input  logic [VALUE_WIDTH-1:0] a_in,
  input  logic [VALUE_WIDTH-1:0] b_in,
  output logic [VALUE_WIDTH-1:0] a_val,
  output logic [VALUE_WIDTH-1:0] b_val
);
  import sose_pkg::*;

  logic here;

  assign here = (wr_idx == IDXW'(INDEX));

  always_ff @(posedge clk) begin
    if (ctrl.wr_a && here) begin
      a_val <= wdata;
    end else if (ctrl.shift_a) begin
      a_val <= a_in;
    end
    if (ctrl.wr_b && here) begin
      b_val <= wdata;
    end else if (ctrl.shift_b) begin
      b_val <= b_in;
    end
  end

endmodule

FILE: sim/tb_small_set_operation_engine_top.sv
`timescale 1ns / 100ps

module tb_small_set_operation_engine_top;
  import sose_pkg::*;

  localparam int CAP = 32;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] rvalue;
    logic [1:0]  kind;
    logic [1:0]  rel;
    logic [5:0]  count;
    logic        last;
  } out_word_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  small_set_operation_engine_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  in_word_t  pending_words[$];
  out_word_t expected_results[$];
  logic [31:0] set_a[CAP];
  logic [31:0] set_b[CAP];
  int  n_a, n_b;
  op_t mode;
  int  errors;
  int  cycles;
  int  hold_off;
  bit  send_idle;
  bit  in_taken;
  bit  out_taken;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic bit member(input logic [31:0] s[CAP], input int n, input logic [31:0] v);
    for (int i = 0; i < n; i++)
      if (s[i] == v) return 1;
    return 0;
  endfunction

  function automatic out_word_t mk(input logic [31:0] v, input kind_t k, input rel_t r,
                                   input int n, input bit l);
    out_word_t o;
    o.rvalue = v; o.kind = k; o.rel = r; o.count = n[5:0]; o.last = l;
    return o;
  endfunction

  task automatic push_list(input logic [31:0] buf_q[$]);
    if (buf_q.size() == 0) expected_results.push_back(mk(0, KIND_EMPTY, REL_NO, 0, 1));
    foreach (buf_q[i])
      expected_results.push_back(mk(buf_q[i], KIND_ELEM, REL_NO, buf_q.size(),
                                    i == buf_q.size() - 1));
  endtask

  task automatic predict_set_op(input in_word_t w);
    logic [31:0] buf_q[$];
    bit sub, extra;
    case (w.action)
      ACT_ADD_A: begin
        if (n_a >= CAP) expected_results.push_back(mk(0, KIND_OVER, REL_NO, 0, 1));
        else begin set_a[n_a] = w.value; n_a++; end
      end
      ACT_ADD_B: begin
        if (n_b >= CAP) expected_results.push_back(mk(0, KIND_OVER, REL_NO, 0, 1));
        else begin set_b[n_b] = w.value; n_b++; end
      end
      ACT_QUERY:
        expected_results.push_back(mk(0, KIND_REL, member(set_a, n_a, w.value) ? REL_YES : REL_NO,
                                      0, 1));
      ACT_CLEAR: begin n_a = 0; n_b = 0; end
      ACT_RUN: begin
        case (mode)
          OP_UNION: begin
            if (n_a + n_b > CAP) expected_results.push_back(mk(0, KIND_OVER, REL_NO, 0, 1));
            else begin
              for (int i = 0; i < n_a; i++) buf_q.push_back(set_a[i]);
              for (int i = 0; i < n_b; i++)
                if (!member(set_a, n_a, set_b[i])) buf_q.push_back(set_b[i]);
              push_list(buf_q);
            end
          end
          OP_INTER: begin
            for (int i = 0; i < n_b; i++)
              if (member(set_a, n_a, set_b[i])) buf_q.push_back(set_b[i]);
            push_list(buf_q);
          end
          OP_DIFF: begin
            for (int i = 0; i < n_a; i++)
              if (!member(set_b, n_b, set_a[i])) buf_q.push_back(set_a[i]);
            push_list(buf_q);
          end
          default: begin
            sub = 1; extra = 0;
            for (int i = 0; i < n_b; i++) if (!member(set_a, n_a, set_b[i])) sub = 0;
            for (int i = 0; i < n_a; i++) if (!member(set_b, n_b, set_a[i])) extra = 1;
            expected_results.push_back(mk(0, KIND_REL, !sub ? REL_NO : (extra ? REL_PROPER : REL_YES),
                                          0, 1));
          end
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    in_taken  <= !rst && s_axis_tvalid && s_axis_tready;
    out_taken <= !rst && m_axis_tvalid && m_axis_tready;
  end

  // driver
  int send_wait;
  in_word_t cur;
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
      send_wait = $urandom_range(0, 14);
    end else if (s_axis_tvalid && !in_taken) begin
    end else if (send_wait > 0 || send_idle || pending_words.size() == 0) begin
      s_axis_tvalid <= 0;
      if (send_wait > 0) send_wait--;
    end else begin
      cur = pending_words.pop_front();
      s_axis_tvalid <= 1;
      s_axis_tuser <= cur.action;
      s_axis_tdata <= cur.value;
      send_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 2) == 0) send_wait = 0;
    end
  end

  always @(posedge clk)
    if (!rst && s_axis_tvalid && s_axis_tready)
      predict_set_op({s_axis_tuser, s_axis_tdata});

  // receiver stall
  int recv_wait;
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
      recv_wait = 0;
    end else if (hold_off > 0) begin
      hold_off--;
      m_axis_tready <= 0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
      if (out_taken)
        recv_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
    end
  end

  // monitor
  out_word_t want;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report("unexpected word", m_axis_tdata, 0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[31:0] !== want.rvalue) report("result_value", m_axis_tdata[31:0], want.rvalue);
        if (m_axis_tuser !== want.kind) report("kind", m_axis_tuser, want.kind);
        if (m_axis_tdata[33:32] !== want.rel) report("relation", m_axis_tdata[33:32], want.rel);
        if (m_axis_tdata[39:34] !== want.count) report("result_count", m_axis_tdata[39:34], want.count);
        if (m_axis_tlast !== want.last) report("last", m_axis_tlast, want.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_value(input int pool);
    if (pool > 0) return $urandom_range(0, pool - 1) - 4;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_word(input action_t a, input logic [31:0] v);
    in_word_t w;
    w.action = a; w.value = v;
    pending_words.push_back(w);
  endtask

  task automatic queue_raw(input logic [2:0] a, input logic [31:0] v);
    in_word_t w;
    w.action = a; w.value = v;
    pending_words.push_back(w);
  endtask

  task automatic drain();
    wait (pending_words.size() == 0);
    @(posedge clk);
    while (s_axis_tvalid || expected_results.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic set_mode(input op_t m);
    @(negedge clk);
    cfg_we <= 1; cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 0;
    mode = m;
  endtask

  task automatic random_phase(input int n);
    int pool, la, lb;
    for (int k = 0; k < n; k++) begin
      pool = $urandom_range(0, 1) ? 10 : 0;
      queue_word(ACT_CLEAR, $urandom);
      la = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 33) : $urandom_range(0, 6);
      lb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 33) : $urandom_range(0, 6);
      for (int i = 0; i < la; i++) queue_word(ACT_ADD_A, rand_value(pool));
      for (int i = 0; i < lb; i++) queue_word(ACT_ADD_B, rand_value(pool));
      repeat ($urandom_range(1, 3)) queue_word(ACT_RUN, $urandom);
      if ($urandom_range(0, 1)) queue_word(ACT_QUERY, rand_value(pool));
      if ($urandom_range(0, 4) == 0) queue_raw(3'($urandom_range(5, 7)), $urandom);
    end
  endtask

  initial begin
    rst = 1; cfg_we = 0; cfg_wdata = 0; s_axis_tvalid = 0; s_axis_tdata = 0;
    s_axis_tuser = 0; m_axis_tready = 0;
    errors = 0; cycles = 0; hold_off = 0; send_idle = 0;
    n_a = 0; n_b = 0; mode = OP_UNION;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empties, extremes, duplicates, full sets, unknown actions
    queue_word(ACT_RUN, 0);
    queue_word(ACT_QUERY, 32'h8000_0000);
    queue_word(ACT_ADD_A, 32'h8000_0000);
    queue_word(ACT_ADD_A, 32'h7fff_ffff);
    queue_word(ACT_ADD_A, 32'h7fff_ffff);
    queue_word(ACT_ADD_B, 32'h7fff_ffff);
    queue_word(ACT_ADD_B, 32'hffff_ffff);
    queue_word(ACT_QUERY, 32'h7fff_ffff);
    queue_word(ACT_QUERY, 0);
    queue_word(ACT_RUN, 32'hffff_ffff);
    queue_raw(3'd5, 0); queue_raw(3'd6, 0); queue_raw(3'd7, 32'hffff_ffff);
    drain();
    for (int m = 1; m < 4; m++) begin
      set_mode(op_t'(m));
      queue_word(ACT_RUN, 0);
      drain();
    end
    // subset cases: empty B, equal sets, proper
    queue_word(ACT_CLEAR, 0);
    queue_word(ACT_RUN, 0);
    queue_word(ACT_ADD_A, 5);
    queue_word(ACT_RUN, 0);
    queue_word(ACT_ADD_B, 5);
    queue_word(ACT_RUN, 0);
    drain();
    // full A, overflow on add and on union; receiver holds off meanwhile
    queue_word(ACT_CLEAR, 0);
    for (int i = 0; i < 33; i++) queue_word(ACT_ADD_A, i);
    for (int i = 0; i < 17; i++) queue_word(ACT_ADD_B, i + 16);
    queue_word(ACT_RUN, 0);
    drain();
    set_mode(OP_INTER);
    hold_off = 400;
    queue_word(ACT_RUN, 0);
    queue_word(ACT_QUERY, 3);
    queue_word(ACT_QUERY, 40);
    queue_word(ACT_RUN, 0);
    drain();
    set_mode(OP_UNION);
    queue_word(ACT_RUN, 0);
    drain();

    set_mode(op_t'($urandom_range(0, 3)));
    random_phase(1);
    drain();
    set_mode(OP_DIFF);
    random_phase(1);
    // sender pauses until all results are in
    wait (pending_words.size() == 0);
    send_idle = 1;
    while (s_axis_tvalid || expected_results.size() != 0) @(posedge clk);
    send_idle = 0;
    random_phase(1);
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
